>>> hw/rtl/csv_field_splitter_core_macros.svh
// Assertion helpers, clocked on i_clk, disabled while i_rst_n is low.
`ifndef CSV_FIELD_SPLITTER_CORE_MACROS_SVH
`define CSV_FIELD_SPLITTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CSVFS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CSVFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSVFS_ASSERT_IMPL(lbl, ante, cons)
`define CSVFS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/csvfs_pkg.sv
`default_nettype none
package csvfs_pkg;

    localparam int LENGTH_BOUND_DEF = 2048;
    localparam int QDEPTH           = 4;
    localparam int CFG_LEN_W        = 11;
    localparam int CFG_FLD_W        = 5;
    localparam int CFG_IDX_W        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIELDS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAW_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUT_LEN = 2'd2;

    localparam logic [CFG_FLD_W-1:0] RST_MAX_FIELDS  = 5'd14;
    localparam logic [CFG_LEN_W-1:0] RST_MAX_RAW_LEN = 11'd1998;
    localparam logic [CFG_LEN_W-1:0] RST_MAX_OUT_LEN = 11'd1999;

    localparam logic [CFG_FLD_W-1:0] FIELDS_HI = 5'd16;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [CFG_FLD_W-1:0] max_fields;
        logic [CFG_LEN_W-1:0] max_raw_len;
        logic [CFG_LEN_W-1:0] max_out_len;
    } t_cfg;

    // one accepted item: optional inserted space, then optional main beat
    typedef struct packed {
        logic       sp;
        logic       mn;
        logic [7:0] ch;
        logic       fd;
        logic       ld;
        logic [3:0] fn;
        logic [4:0] ft;
    } t_entry;

endpackage
`default_nettype wire

>>> hw/rtl/csvfs_front.sv
`default_nettype none
module csvfs_front
    import csvfs_pkg::*;
#(
    parameter int LENGTH_BOUND = LENGTH_BOUND_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_acc,
    input  wire logic   i_func,
    input  wire logic [7:0] i_char,
    output logic        o_push,
    output t_entry      o_entry
);

    localparam int LW = $clog2(LENGTH_BOUND);
    localparam int CW = (LW > CFG_LEN_W) ? LW : CFG_LEN_W;
    localparam logic [CW-1:0] LIM_MAX = CW'(LENGTH_BOUND - 1);

    logic          r_quotes, n_quotes;
    logic [LW-1:0] r_raw, n_raw;
    logic [LW-1:0] r_oc, n_oc;
    logic          r_pend, n_pend;
    logic [4:0]    r_idx, n_idx;
    logic          r_stop, n_stop;

    logic [4:0]    fmax;
    logic [CW-1:0] rlim, olim;
    logic          stopped, keep;

    always_comb begin
        if (i_cfg.max_fields == '0) begin
            fmax = 5'd1;
        end else if (i_cfg.max_fields > FIELDS_HI) begin
            fmax = FIELDS_HI;
        end else begin
            fmax = i_cfg.max_fields;
        end
        rlim = (CW'(i_cfg.max_raw_len) > LIM_MAX) ? LIM_MAX : CW'(i_cfg.max_raw_len);
        olim = (CW'(i_cfg.max_out_len) > LIM_MAX) ? LIM_MAX : CW'(i_cfg.max_out_len);
        stopped = r_stop || (r_idx >= fmax);
        keep = (i_char != CH_LBRACK) && (i_char != CH_RBRACK) && (i_char != CH_APOS)
            && (i_char != CH_LF) && (i_char != CH_CR);
    end

    always_comb begin
        logic [LW-1:0] v_oc;
        v_oc     = r_oc;
        n_quotes = r_quotes;
        n_raw    = r_raw;
        n_oc     = r_oc;
        n_pend   = r_pend;
        n_idx    = r_idx;
        n_stop   = r_stop;
        o_entry.sp = 1'b0;
        o_entry.mn = 1'b0;
        o_entry.ch = i_char;
        o_entry.fd = 1'b0;
        o_entry.ld = 1'b0;
        o_entry.fn = r_idx[3:0];
        o_entry.ft = '0;
        if (i_func) begin
            o_entry.mn = 1'b1;
            o_entry.ch = '0;
            o_entry.fd = 1'b1;
            o_entry.ld = 1'b1;
            if (stopped) begin
                o_entry.fn = 4'(fmax - 5'd1);
                o_entry.ft = fmax;
            end else begin
                o_entry.ft = r_idx + 5'd1;
            end
            n_quotes = 1'b0;
            n_raw    = '0;
            n_oc     = '0;
            n_pend   = 1'b0;
            n_idx    = '0;
            n_stop   = 1'b0;
        end else if (stopped) begin
            n_stop = 1'b1;
        end else if (i_char == CH_QUOTE) begin
            n_quotes = !r_quotes;
        end else if (i_char == CH_COMMA && !r_quotes) begin
            o_entry.mn = 1'b1;
            o_entry.ch = '0;
            o_entry.fd = 1'b1;
            n_raw  = '0;
            n_oc   = '0;
            n_pend = 1'b0;
            n_idx  = r_idx + 5'd1;
            if (r_idx + 5'd1 >= fmax) begin
                n_stop = 1'b1;
            end
        end else if (CW'(r_raw) < rlim) begin
            n_raw = r_raw + 1'b1;
            if (r_pend) begin
                n_pend = 1'b0;
                if (i_char != CH_SPACE && CW'(v_oc) < olim) begin
                    o_entry.sp = 1'b1;
                    v_oc = v_oc + 1'b1;
                end
            end
            if (keep && CW'(v_oc) < olim) begin
                o_entry.mn = 1'b1;
                v_oc = v_oc + 1'b1;
                if (i_char == CH_COMMA) begin
                    n_pend = 1'b1;
                end
            end
            n_oc = v_oc;
        end
        o_push = i_acc && (o_entry.sp || o_entry.mn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quotes <= 1'b0;
            r_raw    <= '0;
            r_oc     <= '0;
            r_pend   <= 1'b0;
            r_idx    <= '0;
            r_stop   <= 1'b0;
        end else if (i_acc) begin
            r_quotes <= n_quotes;
            r_raw    <= n_raw;
            r_oc     <= n_oc;
            r_pend   <= n_pend;
            r_idx    <= n_idx;
            r_stop   <= n_stop;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/csvfs_queue.sv
`default_nettype none
`include "csv_field_splitter_core_macros.svh"
module csvfs_queue
    import csvfs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_entry      o_head
);

    localparam int AW = $clog2(QDEPTH);

    t_entry        r_mem [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt, n_cnt;
    logic          push, pop;

    assign o_full  = (r_cnt == (AW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    `CSVFS_ASSERT_IMPL(a_cnt_bound, 1'b1, r_cnt <= (AW+1)'(QDEPTH))
    `CSVFS_ASSERT_IMPL(a_empty_ptrs, r_cnt == '0, r_wp == r_rp)
    `CSVFS_ASSERT_NEXT(a_push_grows, push && !pop, r_cnt == $past(r_cnt) + 1'b1)

endmodule
`default_nettype wire

>>> hw/rtl/csvfs_back.sv
`default_nettype none
module csvfs_back
    import csvfs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_empty,
    input  wire t_entry i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic [7:0]  o_char,
    output logic [3:0]  o_fn,
    output logic [4:0]  o_ft,
    output logic        o_fd,
    output logic        o_ld,
    output logic        o_last
);

    logic r_phase, n_phase;
    logic on_space, beat;

    assign on_space = !r_phase && i_head.sp;
    assign o_valid  = !i_empty;
    assign beat     = o_valid && i_ready;

    always_comb begin
        o_fn = i_head.fn;
        if (on_space) begin
            o_char = CH_SPACE;
            o_fd   = 1'b0;
            o_ld   = 1'b0;
            o_ft   = '0;
            o_last = !i_head.mn;
        end else begin
            o_char = i_head.ch;
            o_fd   = i_head.fd;
            o_ld   = i_head.ld;
            o_ft   = i_head.ft;
            o_last = 1'b1;
        end
        o_pop   = beat && o_last;
        n_phase = r_phase;
        if (beat) begin
            n_phase = !o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/csv_field_splitter_core.sv
// CSV field splitter.
// Input stream: one beat per line byte (tuser 0, tdata = byte) or an
// end-of-line marker (tuser 1). Quotes toggle quoted mode and are dropped;
// an unquoted comma closes a field. Output stream: one beat per cleaned byte,
// a field-end beat (tuser[0]) per field, tuser[1] on the end-of-line field
// end with the field count in tdata; tlast marks the final beat of an input.
// Config channel: index 0 max_fields, 1 max_raw_len, 2 max_out_len; always
// ready; write only while the block is idle.
// An input byte is classified in the cycle it is accepted; its beats are
// written into a 4-entry queue and leave the block from the queue head.
// Throughput is one input per cycle while the queue is not full; a byte that
// inserts a space after a comma gives two beats, and the queue absorbs that.
// When the receiver stalls the queue fills and s_tready drops once four
// entries wait; output data holds until taken.
// Reset (synchronous, active low) empties the queue, clears the line state
// and loads the register defaults 14, 1998, 1999. No clearing pass.
`default_nettype none
module csv_field_splitter_core
    import csvfs_pkg::*;
#(
    parameter int LENGTH_BOUND = LENGTH_BOUND_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_char
    input  wire logic        i_s_tuser,   // [0] func
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [7:0] out_char, [11:8] field_number,
                                          // [16:12] field_total, [23:17] zero
    output logic [1:0]       o_m_tuser,   // [0] field_done, [1] line_done
    output logic             o_m_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_LEN_W-1:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_entry entry, head;
    logic   push, pop, full, empty, acc;
    logic [7:0] out_char;
    logic [3:0] out_fn;
    logic [4:0] out_ft;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !full;
    assign acc         = i_s_tvalid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_fields  <= RST_MAX_FIELDS;
            r_cfg.max_raw_len <= RST_MAX_RAW_LEN;
            r_cfg.max_out_len <= RST_MAX_OUT_LEN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_FIELDS:  r_cfg.max_fields  <= i_cfg_data[CFG_FLD_W-1:0];
                CFG_MAX_RAW_LEN: r_cfg.max_raw_len <= i_cfg_data;
                CFG_MAX_OUT_LEN: r_cfg.max_out_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    csvfs_front #(
        .LENGTH_BOUND (LENGTH_BOUND)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_acc   (acc),
        .i_func  (i_s_tuser),
        .i_char  (i_s_tdata),
        .o_push  (push),
        .o_entry (entry)
    );

    csvfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    csvfs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_char  (out_char),
        .o_fn    (out_fn),
        .o_ft    (out_ft),
        .o_fd    (o_m_tuser[0]),
        .o_ld    (o_m_tuser[1]),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {7'd0, out_ft, out_fn, out_char};

endmodule
`default_nettype wire

>>> sim/csv_field_splitter_core_tb.sv
`default_nettype none
module csv_field_splitter_core_tb
    import csvfs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 200;

    typedef struct packed {
        logic       eol;
        logic [7:0] ch;
    } t_line_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       fd;
        logic [3:0] fn;
        logic       ld;
        logic [4:0] ft;
        logic       lst;
    } t_field_beat;

    logic i_clk;
    logic i_rst_n;

    logic                 s_vld;
    logic [7:0]           s_data;
    logic                 s_user;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic                 m_rdy;
    logic [23:0]          o_m_tdata;
    logic [1:0]           o_m_tuser;
    logic                 o_m_tlast;
    logic                 cfg_vld;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_LEN_W-1:0] cfg_dat;

    csv_field_splitter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_vld),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_rdy),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (cfg_vld),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_dat)
    );

    t_line_item  line_q[$];
    t_field_beat field_q[$];

    int tx_idle;
    int rx_idle;
    int errors     = 0;
    int cycles     = 0;
    int items_sent;
    int beats_seen = 0;
    int lines_sent;
    int reg_writes;
    logic s_taken  = 1'b0;

    // predictor copy of registers and line state
    logic [CFG_FLD_W-1:0] pr_fields;
    logic [CFG_LEN_W-1:0] pr_raw_len;
    logic [CFG_LEN_W-1:0] pr_out_len;
    logic                 pr_quoted     = 1'b0;
    int                   pr_raw_cnt    = 0;
    int                   pr_out_cnt    = 0;
    logic                 pr_comma_wait = 1'b0;
    int                   pr_field      = 0;
    logic                 pr_halted     = 1'b0;

    function automatic t_field_beat mk_beat(logic [7:0] ch, logic fd, int fn, logic ld, int ft);
        t_field_beat b;
        b.ch  = ch;
        b.fd  = fd;
        b.fn  = 4'(fn);
        b.ld  = ld;
        b.ft  = 5'(ft);
        b.lst = 1'b0;
        return b;
    endfunction

    function automatic void split_predict(logic eol, logic [7:0] c);
        t_field_beat beats[2];
        int n;
        int fmax;
        int olim;
        int rlim;
        logic halted;
        n    = 0;
        fmax = (pr_fields == 0) ? 1 : (pr_fields > FIELDS_HI) ? 16 : int'(pr_fields);
        olim = int'(pr_out_len);
        rlim = int'(pr_raw_len);
        if (olim > LENGTH_BOUND_DEF - 1) olim = LENGTH_BOUND_DEF - 1;
        if (rlim > LENGTH_BOUND_DEF - 1) rlim = LENGTH_BOUND_DEF - 1;
        halted = pr_halted || (pr_field >= fmax);
        if (eol) begin
            if (halted) beats[n] = mk_beat(8'h00, 1'b1, fmax - 1, 1'b1, fmax);
            else        beats[n] = mk_beat(8'h00, 1'b1, pr_field, 1'b1, pr_field + 1);
            n = n + 1;
            pr_quoted     = 1'b0;
            pr_raw_cnt    = 0;
            pr_out_cnt    = 0;
            pr_comma_wait = 1'b0;
            pr_field      = 0;
            pr_halted     = 1'b0;
        end else if (halted) begin
            pr_halted = 1'b1;
        end else if (c == CH_QUOTE) begin
            pr_quoted = !pr_quoted;
        end else if (c == CH_COMMA && !pr_quoted) begin
            beats[n] = mk_beat(8'h00, 1'b1, pr_field, 1'b0, 0);
            n = n + 1;
            pr_raw_cnt    = 0;
            pr_out_cnt    = 0;
            pr_comma_wait = 1'b0;
            pr_field++;
            if (pr_field >= fmax) pr_halted = 1'b1;
        end else if (pr_raw_cnt < rlim) begin
            pr_raw_cnt++;
            if (pr_comma_wait) begin
                pr_comma_wait = 1'b0;
                if (c != CH_SPACE && pr_out_cnt < olim) begin
                    beats[n] = mk_beat(CH_SPACE, 1'b0, pr_field, 1'b0, 0);
                    n = n + 1;
                    pr_out_cnt++;
                end
            end
            if (c != CH_LBRACK && c != CH_RBRACK && c != CH_APOS && c != CH_LF &&
                c != CH_CR && pr_out_cnt < olim) begin
                beats[n] = mk_beat(c, 1'b0, pr_field, 1'b0, 0);
                n = n + 1;
                pr_out_cnt++;
                if (c == CH_COMMA) pr_comma_wait = 1'b1;
            end
        end
        for (int k = 0; k < n; k++) begin
            beats[k].lst = (k == n - 1);
            field_q.push_back(beats[k]);
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // input capture, prediction, output check
    always @(posedge i_clk) begin
        t_field_beat e;
        logic [23:0] exp_data;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d beats outstanding", $time, field_q.size());
            $display("csv_field_splitter_core test failed");
            $finish;
        end
        s_taken = i_rst_n && s_vld && o_s_tready;
        if (s_taken) split_predict(s_user, s_data);
        if (i_rst_n && o_m_tvalid && m_rdy) begin
            beats_seen++;
            if (field_q.size() == 0) begin
                errors++;
                $display("%0t unexpected beat data=%h user=%b last=%b", $time,
                         o_m_tdata, o_m_tuser, o_m_tlast);
            end else begin
                e = field_q.pop_front();
                exp_data = {7'd0, e.ft, e.fn, e.ch};
                if (o_m_tdata !== exp_data || o_m_tuser !== {e.ld, e.fd} ||
                    o_m_tlast !== e.lst) begin
                    errors++;
                    $display("%0t mismatch: expected data=%h user=%b last=%b,",
                             $time, exp_data, {e.ld, e.fd}, e.lst);
                    $display("    got data=%h user=%b last=%b",
                             o_m_tdata, o_m_tuser, o_m_tlast);
                end
            end
        end
    end

    // sender and receiver
    always @(negedge i_clk) begin
        t_line_item it;
        logic nv;
        nv = s_vld;
        if (!i_rst_n) begin
            nv = 1'b0;
            s_data <= 8'h00;
            s_user <= 1'b0;
        end else if (!s_vld || s_taken) begin
            nv = 1'b0;
            if (line_q.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
                it = line_q.pop_front();
                s_data <= it.ch;
                s_user <= it.eol;
                nv = 1'b1;
            end
        end
        s_vld <= nv;
        m_rdy <= i_rst_n && ($urandom_range(0, 99) >= rx_idle);
    end

    function automatic void add_item(logic eol, logic [7:0] c);
        t_line_item it;
        it.eol = eol;
        it.ch  = c;
        line_q.push_back(it);
        items_sent++;
        if (eol) lines_sent++;
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'($urandom_range(8'h61, 8'h7a));
        if (r < 52) return CH_COMMA;
        if (r < 60) return CH_QUOTE;
        if (r < 66) return CH_SPACE;
        if (r < 76) begin
            case ($urandom_range(0, 4))
                0: return CH_LBRACK;
                1: return CH_RBRACK;
                2: return CH_APOS;
                3: return CH_LF;
                default: return CH_CR;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // one line, or a burst of noise, of random content
    function automatic int add_line();
        int n;
        int flds;
        int len;
        n = 0;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                add_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
                n++;
            end
            return n;
        end
        flds = $urandom_range(1, 18);
        for (int f = 0; f < flds; f++) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
            repeat (len) begin
                add_item(1'b0, pick_char());
                n++;
            end
            if (f != flds - 1) begin
                add_item(1'b0, CH_COMMA);
                n++;
            end
        end
        if ($urandom_range(0, 19) != 0) begin
            add_item(1'b1, 8'($urandom_range(0, 255)));
            n++;
        end
        return n;
    endfunction

    task automatic drain();
        while (line_q.size() != 0 || s_vld || field_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_LEN_W-1:0] val);
        @(negedge i_clk);
        cfg_vld <= 1'b1;
        cfg_idx <= idx;
        cfg_dat <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MAX_FIELDS:  pr_fields  = val[CFG_FLD_W-1:0];
            CFG_MAX_RAW_LEN: pr_raw_len = val;
            CFG_MAX_OUT_LEN: pr_out_len = val;
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        cfg_vld <= 1'b0;
    endtask

    function automatic logic [CFG_LEN_W-1:0] pick_len();
        case ($urandom_range(0, 4))
            0: return 11'd0;
            1: return 11'd2047;
            2: return 11'($urandom_range(0, 2047));
            default: return 11'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [CFG_LEN_W-1:0] pick_fields();
        logic [5:0] hi;
        hi = 6'($urandom_range(0, 63));
        case ($urandom_range(0, 4))
            0: return {hi, 5'd1};
            1: return {hi, 5'd16};
            2: return {hi, 5'($urandom_range(0, 31))};
            default: return {hi, 5'($urandom_range(2, 6))};
        endcase
    endfunction

    initial begin
        int n;
        cfg_vld    = 1'b0;
        cfg_idx    = CFG_MAX_FIELDS;
        cfg_dat    = '0;
        items_sent = 0;
        lines_sent = 0;
        reg_writes = 0;
        tx_idle    = 37;
        rx_idle    = 69;
        pr_fields  = RST_MAX_FIELDS;
        pr_raw_len = RST_MAX_RAW_LEN;
        pr_out_len = RST_MAX_OUT_LEN;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // quoted commas with and without inserted space, comma ending a field,
        // removed bytes, zero and all-ones bytes
        add_item(1'b0, CH_QUOTE);
        add_item(1'b0, 8'h61);
        add_item(1'b0, CH_COMMA);
        add_item(1'b0, 8'h62);
        add_item(1'b0, CH_COMMA);
        add_item(1'b0, CH_SPACE);
        add_item(1'b0, CH_COMMA);
        add_item(1'b0, CH_QUOTE);
        add_item(1'b0, CH_COMMA);
        add_item(1'b0, CH_LBRACK);
        add_item(1'b0, CH_RBRACK);
        add_item(1'b0, CH_APOS);
        add_item(1'b0, CH_LF);
        add_item(1'b0, CH_CR);
        add_item(1'b0, 8'h00);
        add_item(1'b0, 8'hff);
        add_item(1'b0, CH_COMMA);
        add_item(1'b1, 8'h00);
        drain();

        // zero limits: one field per line, nothing stored
        write_reg(CFG_MAX_FIELDS, 11'd0);
        write_reg(CFG_MAX_RAW_LEN, 11'd0);
        write_reg(CFG_MAX_OUT_LEN, 11'd0);
        add_item(1'b0, 8'h78);
        add_item(1'b0, CH_COMMA);
        add_item(1'b0, 8'h79);
        add_item(1'b1, 8'hff);
        drain();

        // field limit above range, output limit of one blocks the inserted space
        write_reg(CFG_MAX_FIELDS, 11'h7ff);
        write_reg(CFG_MAX_RAW_LEN, 11'd2047);
        write_reg(CFG_MAX_OUT_LEN, 11'd1);
        add_item(1'b0, CH_QUOTE);
        add_item(1'b0, CH_COMMA);
        add_item(1'b0, 8'h7a);
        add_item(1'b0, CH_QUOTE);
        add_item(1'b1, 8'h00);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            tx_idle = (p / 2 == 0) ? 37 : (p / 2 == 1) ? 69 : 0;
            rx_idle = (p / 2 == 0) ? 69 : (p / 2 == 1) ? 37 : 0;
            write_reg(CFG_MAX_FIELDS, pick_fields());
            write_reg(CFG_MAX_RAW_LEN, pick_len());
            write_reg(CFG_MAX_OUT_LEN, pick_len());
            n = 0;
            while (n < PHASE_ITEMS / 2) n += add_line();
            // sender holds off until the block has emptied
            drain();
            while (n < PHASE_ITEMS) n += add_line();
            drain();
        end

        // close any line left open so its state ends clean
        add_item(1'b1, 8'h00);
        drain();
        repeat (16) @(posedge i_clk);

        $display("%0d items in %0d lines, %0d output beats, %0d register writes",
                 items_sent, lines_sent, beats_seen, reg_writes);
        $display("mismatches: %0d", errors);
        if (errors == 0 && field_q.size() == 0) begin
            $display("csv_field_splitter_core test passed");
        end else begin
            $display("csv_field_splitter_core test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
+incdir+hw/rtl
hw/rtl/csvfs_pkg.sv
hw/rtl/csvfs_front.sv
hw/rtl/csvfs_queue.sv
hw/rtl/csvfs_back.sv
hw/rtl/csv_field_splitter_core.sv
sim/csv_field_splitter_core_tb.sv
